// ===== src/fdpb_pkg.sv =====
// Package for the frame-difference projection bounding box core.
// Holds frame limits, field widths, register indexes and the saturating add.
// No dependencies.
`default_nettype none

package fdpb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  localparam int PIX_W  = 8;
  localparam int CNT_W  = 11;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_LIGHT_THR = 2'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_THR = 2'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd3;

  // Count plus a one-bit mark, held at the top of the count range.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
                                               input logic             m);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{CNT_W{1'b0}}, m};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/frame_diff_projection_bbox_core.sv =====
// Frame-difference projection bounding box core: one pixel pair per clock while in_stall is low.
// Result path: the box goes from the stage 1 registers to the output register or pending slot.
// Throughput: one pixel request per cycle while in_stall is low; the single column-count RAM
// port pair (one read, one write per cycle) sets that rate, with forwarding between neighbors.
// Reset: synchronous, active low; control and configuration registers return to their
// defaults and the position counters to the frame origin. The column RAM is not cleared.
`default_nettype none

module frame_diff_projection_bbox_core (
  input  wire                            clk,
  input  wire                            rst_n,
  // Configuration write port
  input  wire                            cfg_we,
  input  wire [fdpb_pkg::IDX_W-1:0]      cfg_index,
  input  wire [fdpb_pkg::CFG_W-1:0]      cfg_wdata,
  // Pixel pair requests
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [fdpb_pkg::PIX_W-1:0]      in_prev_pixel,
  input  wire [fdpb_pkg::PIX_W-1:0]      in_cur_pixel,
  // Box result requests
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [fdpb_pkg::POS_W-1:0]     out_box_left,
  output logic [fdpb_pkg::POS_W-1:0]     out_box_top,
  output logic [fdpb_pkg::POS_W-1:0]     out_box_right,
  output logic [fdpb_pkg::POS_W-1:0]     out_box_bottom,
  output logic                           out_box_found
);

  import fdpb_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] light_thr_r;
  logic [CNT_W-1:0] count_thr_r;
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_thr_r    <= PIX_W'(100);
      count_thr_r    <= CNT_W'(100);
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_THR: light_thr_r    <= cfg_wdata[PIX_W-1:0];
        REG_COUNT_THR: count_thr_r    <= cfg_wdata[CNT_W-1:0];
        REG_WIDTH:     frame_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:    frame_height_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Last usable column and row: a zero size counts as one, and sizes above
  // the frame limits saturate at the limit.
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  always_comb begin
    if (frame_width_r == '0) begin
      wm1 = '0;
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(frame_width_r - DIM_W'(1));
    end
    if (frame_height_r == '0) begin
      hm1 = '0;
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(frame_height_r - DIM_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept a pixel pair, mark it, track the raster position and the
  // row projection, and issue the column RAM read.
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic [PIX_W-1:0] diff;
  logic             mark;
  logic [COL_W-1:0] col;
  logic             row_end;
  logic             last_row;
  logic             frame_end;

  logic [COL_W-1:0] col_pos_r,   col_pos_nxt;
  logic [ROW_W-1:0] row_pos_r,   row_pos_nxt;
  logic [CNT_W-1:0] row_cnt_r,   row_cnt_nxt;
  logic [ROW_W-1:0] row_first_r, row_first_nxt;
  logic [ROW_W-1:0] row_last_r,  row_last_nxt;
  logic             row_seen_r,  row_seen_nxt;

  // Row bounds as they stand after this pixel, before any frame clear.
  logic [ROW_W-1:0] row_first_upd;
  logic [ROW_W-1:0] row_last_upd;
  logic             row_seen_upd;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    diff      = (in_prev_pixel > in_cur_pixel) ? (in_prev_pixel - in_cur_pixel)
                                               : (in_cur_pixel - in_prev_pixel);
    mark      = (diff <= light_thr_r);
    col       = (col_pos_r <= wm1) ? col_pos_r : wm1;
    row_end   = (col_pos_r >= wm1);
    last_row  = (row_pos_r >= hm1);
    frame_end = row_end && last_row;

    row_cnt_nxt = (col_pos_r == '0) ? {{(CNT_W-1){1'b0}}, mark}
                                    : sat_inc(row_cnt_r, mark);

    row_first_upd = row_first_r;
    row_last_upd  = row_last_r;
    row_seen_upd  = row_seen_r;
    if (row_end && (row_cnt_nxt > count_thr_r)) begin
      if (!row_seen_r) begin
        row_first_upd = row_pos_r;
        row_seen_upd  = 1'b1;
      end
      row_last_upd = row_pos_r;
    end

    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    row_first_nxt = row_first_upd;
    row_last_nxt  = row_last_upd;
    row_seen_nxt  = row_seen_upd;
    if (!row_end) begin
      col_pos_nxt = col_pos_r + COL_W'(1);
    end else if (!last_row) begin
      col_pos_nxt = '0;
      row_pos_nxt = row_pos_r + ROW_W'(1);
    end else begin
      // A new frame starts with the next pixel.
      col_pos_nxt   = '0;
      row_pos_nxt   = '0;
      row_cnt_nxt   = '0;
      row_first_nxt = '0;
      row_last_nxt  = '0;
      row_seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      row_cnt_r   <= '0;
      row_first_r <= '0;
      row_last_r  <= '0;
      row_seen_r  <= 1'b0;
    end else if (in_acc) begin
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      row_cnt_r   <= row_cnt_nxt;
      row_first_r <= row_first_nxt;
      row_last_r  <= row_last_nxt;
      row_seen_r  <= row_seen_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers. Stage 1 never holds: the input stall below guarantees a
  // slot for its result, so the RAM read data is always used the next cycle.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_mark_r;
  logic             s1_row0_r;
  logic             s1_last_row_r;
  logic             s1_frame_end_r;
  logic [ROW_W-1:0] s1_row_first_r;
  logic [ROW_W-1:0] s1_row_last_r;
  logic             s1_row_seen_r;
  logic [COL_W-1:0] s1_wm1_r;
  logic [ROW_W-1:0] s1_hm1_r;
  logic             fwd_hit_r;
  logic [CNT_W-1:0] fwd_data_r;
  logic [CNT_W-1:0] mem_rd_r;
  logic [CNT_W-1:0] cc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r       <= col;
      s1_mark_r      <= mark;
      s1_row0_r      <= (row_pos_r == '0);
      s1_last_row_r  <= last_row;
      s1_frame_end_r <= frame_end;
      s1_row_first_r <= row_first_upd;
      s1_row_last_r  <= row_last_upd;
      s1_row_seen_r  <= row_seen_upd;
      s1_wm1_r       <= wm1;
      s1_hm1_r       <= hm1;
      // The RAM reads the old word when the same entry is written in the same
      // cycle, so the count being written by stage 1 is forwarded instead.
      fwd_hit_r      <= s1_valid_r && (s1_col_r == col);
      fwd_data_r     <= cc;
    end
  end

  // ---------------------------------------------------------------------------
  // Column count RAM: read in stage 0, modified and written back in stage 1.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] col_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      col_mem[s1_col_r] <= cc;
    end
    if (in_acc) begin
      mem_rd_r <= col_mem[col];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: column count update, column bounds and the frame result.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] col_old;
  logic [COL_W-1:0] col_first_r, col_first_nxt;
  logic [COL_W-1:0] col_last_r,  col_last_nxt;
  logic             col_seen_r,  col_seen_nxt;
  logic [COL_W-1:0] col_first_upd;
  logic [COL_W-1:0] col_last_upd;
  logic             col_seen_upd;
  logic             found;
  logic             res_valid;
  logic [POS_W-1:0] res_left;
  logic [POS_W-1:0] res_top;
  logic [POS_W-1:0] res_right;
  logic [POS_W-1:0] res_bottom;

  always_comb begin
    col_old = fwd_hit_r ? fwd_data_r : mem_rd_r;
    cc      = s1_row0_r ? {{(CNT_W-1){1'b0}}, s1_mark_r} : sat_inc(col_old, s1_mark_r);

    col_first_upd = col_first_r;
    col_last_upd  = col_last_r;
    col_seen_upd  = col_seen_r;
    if (s1_last_row_r && (cc > count_thr_r)) begin
      if (!col_seen_r) begin
        col_first_upd = s1_col_r;
        col_seen_upd  = 1'b1;
      end
      col_last_upd = s1_col_r;
    end

    // A box that collapses onto the origin is treated as no box.
    found = col_seen_upd && s1_row_seen_r &&
            !((col_first_upd == '0) && (col_last_upd == '0) &&
              (s1_row_first_r == '0) && (s1_row_last_r == '0));

    if (found) begin
      res_left   = POS_W'(col_first_upd);
      res_top    = POS_W'(s1_row_first_r);
      res_right  = POS_W'(col_last_upd);
      res_bottom = POS_W'(s1_row_last_r);
    end else begin
      res_left   = '0;
      res_top    = '0;
      res_right  = POS_W'(s1_wm1_r);
      res_bottom = POS_W'(s1_hm1_r);
    end
    res_valid = s1_valid_r && s1_frame_end_r;

    if (res_valid) begin
      col_first_nxt = '0;
      col_last_nxt  = '0;
      col_seen_nxt  = 1'b0;
    end else begin
      col_first_nxt = col_first_upd;
      col_last_nxt  = col_last_upd;
      col_seen_nxt  = col_seen_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_first_r <= '0;
      col_last_r  <= '0;
      col_seen_r  <= 1'b0;
    end else if (s1_valid_r) begin
      col_first_r <= col_first_nxt;
      col_last_r  <= col_last_nxt;
      col_seen_r  <= col_seen_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus one pending slot. A result that finds the output
  // register full and stalled waits in the pending slot. Input is stalled when
  // the pending slot is taken, or when a result in stage 1 is about to fill it
  // because the output register is full and stalled.
  // ---------------------------------------------------------------------------
  logic             out_valid_r;
  logic [POS_W-1:0] out_left_r, out_top_r, out_right_r, out_bottom_r;
  logic             out_found_r;
  logic             pend_valid_r;
  logic [POS_W-1:0] pend_left_r, pend_top_r, pend_right_r, pend_bottom_r;
  logic             pend_found_r;
  logic             out_take;
  logic             out_load_res;
  logic             out_load_pend;
  logic             pend_load;

  assign out_take      = out_valid_r && !out_stall;
  assign out_load_pend = pend_valid_r && out_take;
  assign out_load_res  = res_valid && !pend_valid_r && (!out_valid_r || out_take);
  assign pend_load     = res_valid && !out_load_res;

  assign in_stall = pend_valid_r || (res_valid && out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_load_res || out_load_pend || (out_valid_r && !out_take);
      pend_valid_r <= pend_load || (pend_valid_r && !out_load_pend);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_pend) begin
      out_left_r   <= pend_left_r;
      out_top_r    <= pend_top_r;
      out_right_r  <= pend_right_r;
      out_bottom_r <= pend_bottom_r;
      out_found_r  <= pend_found_r;
    end else if (out_load_res) begin
      out_left_r   <= res_left;
      out_top_r    <= res_top;
      out_right_r  <= res_right;
      out_bottom_r <= res_bottom;
      out_found_r  <= found;
    end
    if (pend_load) begin
      pend_left_r   <= res_left;
      pend_top_r    <= res_top;
      pend_right_r  <= res_right;
      pend_bottom_r <= res_bottom;
      pend_found_r  <= found;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_box_left   = out_left_r;
  assign out_box_top    = out_top_r;
  assign out_box_right  = out_right_r;
  assign out_box_bottom = out_bottom_r;
  assign out_box_found  = out_found_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The pending slot is only ever filled behind a full output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without a full output register");

  // A result from stage 1 always finds a free slot; none is dropped.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!pend_valid_r || out_take))
    else $error("frame result arrived with no free slot");

  // Stage 1 holds exactly the request accepted in the cycle before.
  a_s1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request did not reach the column update stage");

  // A found box is never the origin point.
  a_box_not_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |->
      !((out_left_r == '0) && (out_top_r == '0) &&
        (out_right_r == '0) && (out_bottom_r == '0)))
    else $error("box reported at the origin point");

endmodule

`default_nettype wire
